### hw/rtl/cbfd_pkg.sv
// shared constants and types for the cubic bezier forward-difference evaluator
package cbfd_pkg;

	localparam int MAX_RESOLUTION = 64;
	localparam int COORD_WIDTH    = 32;
	localparam int ACC_FRAC       = 16;

	localparam int RES_W = 7;
	localparam logic [RES_W-1:0] RES_RESET = 7'd12;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// word index of the resolution register (paddr[2])
	localparam logic REG_RESOLUTION = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_NUM,
		ST_XFORM,
		ST_LAUNCH,
		ST_DIV,
		ST_STORE,
		ST_EMIT
	} state_t;

	// difference terms in the order they are divided
	typedef enum logic [1:0] {
		TERM_CUBIC,
		TERM_QUAD,
		TERM_LINEAR
	} term_t;

endpackage

### hw/rtl/cbfd_apb.sv
// apb register block holding the resolution register
module cbfd_apb (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cbfd_pkg::APB_AW-1:0]   paddr,
	input  logic [cbfd_pkg::APB_DW-1:0]   pwdata,
	output logic [cbfd_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	output logic [cbfd_pkg::RES_W-1:0]    resolution
);

	logic [cbfd_pkg::RES_W-1:0] res_q;
	logic                       hit;

	assign pready     = 1'b1;
	assign hit        = (paddr[2] == cbfd_pkg::REG_RESOLUTION);
	assign resolution = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= cbfd_pkg::RES_RESET;
		end else if (psel && penable && pwrite && pready && hit) begin
			res_q <= pwdata[cbfd_pkg::RES_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata[cbfd_pkg::RES_W-1:0] = res_q;
		end
	end

endmodule

### hw/rtl/cbfd_div.sv
// restoring unsigned divider, one quotient bit per cycle
module cbfd_div #(
	parameter int DIVIDEND_W = 52,
	parameter int DIVISOR_W  = 19
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIVIDEND_W);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  den_q;
	logic [DIVIDEND_W-1:0] quo_q;

	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  ge;
	logic [DIVISOR_W-1:0]  rem_next;

	always_comb begin
		trial    = {rem_q, quo_q[DIVIDEND_W-1]};
		diff     = trial - {1'b0, den_q};
		ge       = (trial >= {1'b0, den_q});
		rem_next = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend bits shift out at the top while quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### hw/rtl/cubic_bezier_forward_difference.sv
// cubic bezier segment evaluator: coefficient setup on a shared divider, then forward differencing
//
//  channel | handshake                        | word
//  --------+----------------------------------+------------------------------------------
//  in      | in_valid / in_stall              | p0..p3 x/y/z, signed Q16.16
//  out     | out_valid / out_stall            | point_x/y/z, last_point
//  cfg     | apb psel/penable/pwrite, paddr   | resolution at byte 0
//
// one segment runs nine scaled divisions one after another on the bit-serial divider, whose
// dividend is DIV_W = COORD_WIDTH+20 bits wide, one quotient bit per cycle, then one point per
// cycle while out is not stalled.
// in_stall stays high from acceptance until the last point is loaded into the output register.
// reset clears the sequencer, the divider control and out_valid; resolution resets to 12.
module cubic_bezier_forward_difference #(
	parameter int MAX_RESOLUTION = cbfd_pkg::MAX_RESOLUTION,
	parameter int COORD_WIDTH    = cbfd_pkg::COORD_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cbfd_pkg::APB_AW-1:0]   paddr,
	input  logic [cbfd_pkg::APB_DW-1:0]   pwdata,
	output logic [cbfd_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,

	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] p0_x,
	input  logic signed [COORD_WIDTH-1:0] p0_y,
	input  logic signed [COORD_WIDTH-1:0] p0_z,
	input  logic signed [COORD_WIDTH-1:0] p1_x,
	input  logic signed [COORD_WIDTH-1:0] p1_y,
	input  logic signed [COORD_WIDTH-1:0] p1_z,
	input  logic signed [COORD_WIDTH-1:0] p2_x,
	input  logic signed [COORD_WIDTH-1:0] p2_y,
	input  logic signed [COORD_WIDTH-1:0] p2_z,
	input  logic signed [COORD_WIDTH-1:0] p3_x,
	input  logic signed [COORD_WIDTH-1:0] p3_y,
	input  logic signed [COORD_WIDTH-1:0] p3_z,

	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0] point_x,
	output logic signed [COORD_WIDTH-1:0] point_y,
	output logic signed [COORD_WIDTH-1:0] point_z,
	output logic                          last_point
);

	localparam int ACC_FRAC = cbfd_pkg::ACC_FRAC;
	localparam int ACC_W    = COORD_WIDTH + ACC_FRAC;
	localparam int EXT      = 4;
	localparam int NUM_W    = COORD_WIDTH + EXT;
	localparam int DIV_W    = NUM_W + ACC_FRAC;
	localparam int X_W      = DIV_W + 1;
	localparam int N_W      = $clog2(MAX_RESOLUTION + 1);
	localparam int N2_W     = $clog2(MAX_RESOLUTION * MAX_RESOLUTION + 1);
	localparam int N3_W     = $clog2(MAX_RESOLUTION * MAX_RESOLUTION * MAX_RESOLUTION + 1);
	localparam int RES_W    = cbfd_pkg::RES_W;

	// configuration
	logic [RES_W-1:0] resolution;

	cbfd_apb u_apb (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.resolution (resolution)
	);

	// sequencer
	cbfd_pkg::state_t state_q, state_d;
	cbfd_pkg::term_t  term_q;
	logic [1:0]       axis_q;
	logic [N_W-1:0]   cnt_q;

	logic in_accept;
	logic div_start;
	logic div_done;
	logic emit_load;
	logic emit_last;

	// segment registers
	logic [COORD_WIDTH-1:0] pin_q [0:3][0:2];
	logic [N_W-1:0]         n_q;
	logic [N2_W-1:0]        n2_q;
	logic [N3_W-1:0]        n3_q;
	logic signed [NUM_W-1:0] num_q;
	logic [X_W-1:0]         x_q;
	logic                   neg_q;
	logic [ACC_W-1:0]       rt_q;

	logic [ACC_W-1:0] q0_q [0:2];
	logic [ACC_W-1:0] q1_q [0:2];
	logic [ACC_W-1:0] q2_q [0:2];
	logic [ACC_W-1:0] q3_q [0:2];

	logic                   out_valid_q;
	logic [COORD_WIDTH-1:0] pt_q [0:2];
	logic                   last_q;

	// resolution clamp, square and cube
	logic [N_W-1:0]      n_clamp;
	logic [2*N_W-1:0]    n_sq;
	logic [N2_W+N_W-1:0] n_cube;

	always_comb begin
		if (resolution == '0) begin
			n_clamp = N_W'(1);
		end else if (resolution > RES_W'(MAX_RESOLUTION)) begin
			n_clamp = N_W'(MAX_RESOLUTION);
		end else begin
			n_clamp = resolution[N_W-1:0];
		end
		n_sq   = n_clamp * n_clamp;
		n_cube = n2_q * n_q;
	end

	// divisor for the current term
	logic [N3_W-1:0] den_sel;

	always_comb begin
		case (term_q)
			cbfd_pkg::TERM_CUBIC:  den_sel = n3_q;
			cbfd_pkg::TERM_QUAD:   den_sel = {{(N3_W-N2_W){1'b0}}, n2_q};
			cbfd_pkg::TERM_LINEAR: den_sel = {{(N3_W-N_W){1'b0}}, n_q};
			default:               den_sel = n3_q;
		endcase
	end

	// numerators a, b, c for the current axis
	logic signed [NUM_W-1:0] p0e, p1e, p2e, p3e;
	logic signed [NUM_W-1:0] d10, d12, t_b, num_a, num_b, num_c, num_sel;

	always_comb begin
		p0e   = {{EXT{pin_q[0][axis_q][COORD_WIDTH-1]}}, pin_q[0][axis_q]};
		p1e   = {{EXT{pin_q[1][axis_q][COORD_WIDTH-1]}}, pin_q[1][axis_q]};
		p2e   = {{EXT{pin_q[2][axis_q][COORD_WIDTH-1]}}, pin_q[2][axis_q]};
		p3e   = {{EXT{pin_q[3][axis_q][COORD_WIDTH-1]}}, pin_q[3][axis_q]};
		d10   = p1e - p0e;
		d12   = p1e - p2e;
		t_b   = p0e - (p1e <<< 1) + p2e;
		num_a = (d10 <<< 1) + d10;
		num_b = (t_b <<< 1) + t_b;
		num_c = p3e - p0e + (d12 <<< 1) + d12;
		case (term_q)
			cbfd_pkg::TERM_CUBIC:  num_sel = num_c;
			cbfd_pkg::TERM_QUAD:   num_sel = num_b;
			cbfd_pkg::TERM_LINEAR: num_sel = num_a;
			default:               num_sel = num_c;
		endcase
	end

	// floor((num*2^frac + floor(d/2)) / d), negative side via the magnitude with a ceiling offset
	logic [X_W-1:0] x_next;
	logic [X_W-1:0] den_ext;
	logic [X_W-1:0] u_full;

	always_comb begin
		den_ext = {{(X_W-N3_W){1'b0}}, den_sel};
		x_next  = {num_q[NUM_W-1], num_q, {ACC_FRAC{1'b0}}} + (den_ext >> 1);
		u_full  = x_q[X_W-1] ? (den_ext - X_W'(1) - x_q) : x_q;
	end

	logic [DIV_W-1:0] quotient;

	cbfd_div #(
		.DIVIDEND_W (DIV_W),
		.DIVISOR_W  (N3_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (u_full[DIV_W-1:0]),
		.divisor  (den_sel),
		.done     (div_done),
		.quotient (quotient)
	);

	// next state and strobes
	assign in_accept = in_valid && !in_stall;
	assign in_stall  = (state_q != cbfd_pkg::ST_IDLE);
	assign emit_last = (cnt_q == n_q - N_W'(1));

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		emit_load = 1'b0;
		case (state_q)
			cbfd_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = cbfd_pkg::ST_PREP;
				end
			end
			cbfd_pkg::ST_PREP:   state_d = cbfd_pkg::ST_NUM;
			cbfd_pkg::ST_NUM:    state_d = cbfd_pkg::ST_XFORM;
			cbfd_pkg::ST_XFORM:  state_d = cbfd_pkg::ST_LAUNCH;
			cbfd_pkg::ST_LAUNCH: begin
				div_start = 1'b1;
				state_d   = cbfd_pkg::ST_DIV;
			end
			cbfd_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = cbfd_pkg::ST_STORE;
				end
			end
			cbfd_pkg::ST_STORE: begin
				if (term_q == cbfd_pkg::TERM_LINEAR && axis_q == 2'd2) begin
					state_d = cbfd_pkg::ST_EMIT;
				end else begin
					state_d = cbfd_pkg::ST_NUM;
				end
			end
			cbfd_pkg::ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					emit_load = 1'b1;
					if (emit_last) begin
						state_d = cbfd_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = cbfd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cbfd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q <= cbfd_pkg::TERM_CUBIC;
			axis_q <= '0;
			cnt_q  <= '0;
		end else begin
			case (state_q)
				cbfd_pkg::ST_PREP: begin
					term_q <= cbfd_pkg::TERM_CUBIC;
					axis_q <= '0;
					cnt_q  <= '0;
				end
				cbfd_pkg::ST_STORE: begin
					case (term_q)
						cbfd_pkg::TERM_CUBIC: term_q <= cbfd_pkg::TERM_QUAD;
						cbfd_pkg::TERM_QUAD:  term_q <= cbfd_pkg::TERM_LINEAR;
						default: begin
							term_q <= cbfd_pkg::TERM_CUBIC;
							if (axis_q != 2'd2) begin
								axis_q <= axis_q + 2'd1;
							end
						end
					endcase
				end
				cbfd_pkg::ST_EMIT: begin
					if (emit_load) begin
						cnt_q <= cnt_q + N_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// setup datapath
	always_ff @(posedge clk) begin
		if (in_accept) begin
			pin_q[0][0] <= p0_x;
			pin_q[0][1] <= p0_y;
			pin_q[0][2] <= p0_z;
			pin_q[1][0] <= p1_x;
			pin_q[1][1] <= p1_y;
			pin_q[1][2] <= p1_z;
			pin_q[2][0] <= p2_x;
			pin_q[2][1] <= p2_y;
			pin_q[2][2] <= p2_z;
			pin_q[3][0] <= p3_x;
			pin_q[3][1] <= p3_y;
			pin_q[3][2] <= p3_z;
			n_q         <= n_clamp;
			n2_q        <= n_sq[N2_W-1:0];
		end
		if (state_q == cbfd_pkg::ST_PREP) begin
			n3_q <= n_cube[N3_W-1:0];
		end
		if (state_q == cbfd_pkg::ST_NUM) begin
			num_q <= num_sel;
		end
		if (state_q == cbfd_pkg::ST_XFORM) begin
			x_q <= x_next;
		end
		if (state_q == cbfd_pkg::ST_LAUNCH) begin
			neg_q <= x_q[X_W-1];
		end
		if (state_q == cbfd_pkg::ST_DIV && div_done) begin
			rt_q <= neg_q ? (~quotient[ACC_W-1:0] + ACC_W'(1)) : quotient[ACC_W-1:0];
		end
	end

	// difference accumulators, one lane per axis
	logic [ACC_W-1:0] rt_x6;
	assign rt_x6 = (rt_q << 2) + (rt_q << 1);

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			if (state_q == cbfd_pkg::ST_PREP) begin
				q0_q[a] <= {pin_q[0][a], {ACC_FRAC{1'b0}}};
			end else if (state_q == cbfd_pkg::ST_STORE && axis_q == 2'(a)) begin
				case (term_q)
					cbfd_pkg::TERM_CUBIC: begin
						q1_q[a] <= rt_q;
						q2_q[a] <= rt_x6;
						q3_q[a] <= rt_x6;
					end
					cbfd_pkg::TERM_QUAD: begin
						q1_q[a] <= q1_q[a] + rt_q;
						q2_q[a] <= q2_q[a] + (rt_q << 1);
					end
					default: begin
						q1_q[a] <= q1_q[a] + rt_q;
					end
				endcase
			end else if (emit_load) begin
				q0_q[a] <= q0_q[a] + q1_q[a];
				q1_q[a] <= q1_q[a] + q2_q[a];
				q2_q[a] <= q2_q[a] + q3_q[a];
			end
		end
	end

	// output register
	logic [ACC_W-1:0] rnd [0:2];

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			rnd[a] = q0_q[a] + (ACC_W'(1) << (ACC_FRAC - 1));
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			for (int a = 0; a < 3; a++) begin
				pt_q[a] <= rnd[a][ACC_W-1:ACC_FRAC];
			end
			last_q <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign point_x    = pt_q[0];
	assign point_y    = pt_q[1];
	assign point_z    = pt_q[2];
	assign last_point = last_q;

	// checks
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == cbfd_pkg::ST_DIV)
		else $error("divider finished outside the wait state");

	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cbfd_pkg::ST_EMIT |-> cnt_q < n_q)
		else $error("point count ran past resolution");

	a_last_word: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_load && emit_last) |=> (state_q == cbfd_pkg::ST_IDLE && out_valid && last_point))
		else $error("final point not flagged or sequencer not back to idle");

	a_n_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != cbfd_pkg::ST_IDLE |-> (n_q != '0 && n_q <= N_W'(MAX_RESOLUTION)))
		else $error("segment resolution out of range");

endmodule

### test/cubic_bezier_forward_difference_checker.sv
// checker: predicts curve points for each accepted segment and compares the out channel
module cubic_bezier_forward_difference_checker
	import cbfd_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [APB_AW-1:0]             paddr,
	input  logic [APB_DW-1:0]             pwdata,
	input  logic                          pready,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] p0_x,
	input  logic signed [COORD_WIDTH-1:0] p0_y,
	input  logic signed [COORD_WIDTH-1:0] p0_z,
	input  logic signed [COORD_WIDTH-1:0] p1_x,
	input  logic signed [COORD_WIDTH-1:0] p1_y,
	input  logic signed [COORD_WIDTH-1:0] p1_z,
	input  logic signed [COORD_WIDTH-1:0] p2_x,
	input  logic signed [COORD_WIDTH-1:0] p2_y,
	input  logic signed [COORD_WIDTH-1:0] p2_z,
	input  logic signed [COORD_WIDTH-1:0] p3_x,
	input  logic signed [COORD_WIDTH-1:0] p3_y,
	input  logic signed [COORD_WIDTH-1:0] p3_z,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic signed [COORD_WIDTH-1:0] point_z,
	input  logic                          last_point,
	output int                            failures,
	output int                            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ACC_W = COORD_WIDTH + ACC_FRAC;
	localparam int MAX_PRINTED = 40;

	typedef struct packed {
		logic [COORD_WIDTH-1:0] x;
		logic [COORD_WIDTH-1:0] y;
		logic [COORD_WIDTH-1:0] z;
		logic                   last;
	} curve_point_t;

	curve_point_t     points_due[$];
	logic [RES_W-1:0] resolution_setting;

	// floor(num * 2^ACC_FRAC / den + 1/2) as an accumulator pattern, den > 0
	function automatic logic [ACC_W-1:0] scaled_term(input longint num, input longint den);
		longint     q;
		longint     r;
		logic [63:0] qb;
		logic [63:0] rb;
		logic [63:0] frac;
		q = num / den;
		r = num % den;
		if (r < 0) begin
			q = q - 1;
			r = r + den;
		end
		qb = q;
		rb = r;
		frac = ((rb << ACC_FRAC) + 64'(den / 2)) / 64'(den);
		return ACC_W'((qb << ACC_FRAC) + frac);
	endfunction

	task automatic predict_curve_points(input logic [11:0][COORD_WIDTH-1:0] ctrl);
		longint                 n;
		longint                 p0;
		longint                 p1;
		longint                 p2;
		longint                 p3;
		logic [ACC_W-1:0]       acc [3][4];
		logic [ACC_W-1:0]       rt1;
		logic [ACC_W-1:0]       rt2;
		logic [ACC_W-1:0]       rt3;
		logic [ACC_W-1:0]       rounded;
		logic [COORD_WIDTH-1:0] coord [3];
		curve_point_t           pt;
		n = resolution_setting;
		// zero counts as one point, anything above the maximum saturates
		if (n < 1)
			n = 1;
		if (n > MAX_RESOLUTION)
			n = MAX_RESOLUTION;
		for (int axis = 0; axis < 3; axis++) begin
			p0 = $signed(ctrl[axis]);
			p1 = $signed(ctrl[3 + axis]);
			p2 = $signed(ctrl[6 + axis]);
			p3 = $signed(ctrl[9 + axis]);
			rt1 = scaled_term(3 * (p1 - p0), n);
			rt2 = scaled_term(3 * (p0 - 2 * p1 + p2), n * n);
			rt3 = scaled_term(p3 - p0 + 3 * (p1 - p2), n * n * n);
			acc[axis][0] = {ctrl[axis], {ACC_FRAC{1'b0}}};
			acc[axis][1] = rt1 + rt2 + rt3;
			acc[axis][2] = 2 * rt2 + 6 * rt3;
			acc[axis][3] = 6 * rt3;
		end
		for (int i = 0; i < n; i++) begin
			for (int axis = 0; axis < 3; axis++) begin
				rounded = acc[axis][0] + (ACC_W'(1) << (ACC_FRAC - 1));
				coord[axis] = rounded[ACC_W-1:ACC_FRAC];
				acc[axis][0] = acc[axis][0] + acc[axis][1];
				acc[axis][1] = acc[axis][1] + acc[axis][2];
				acc[axis][2] = acc[axis][2] + acc[axis][3];
			end
			pt.x = coord[0];
			pt.y = coord[1];
			pt.z = coord[2];
			pt.last = (i == n - 1);
			points_due.push_back(pt);
		end
	endtask

	task automatic note_failure(input string msg);
		failures++;
		if (failures <= MAX_PRINTED)
			$display("%0t ns checker: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [COORD_WIDTH-1:0] want,
			input logic [COORD_WIDTH-1:0] got);
		if (got !== want)
			note_failure($sformatf("%s is %h, predicted %h", name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		curve_point_t want;
		if (!arst_n) begin
			resolution_setting = RES_RESET;
			points_due.delete();
			pending = 0;
		end else begin
			// writes to addresses beyond the register list leave resolution alone
			if (psel && penable && pwrite && pready && paddr[APB_AW-1:2] == REG_RESOLUTION)
				resolution_setting = pwdata[RES_W-1:0];
			if (in_valid && !in_stall)
				predict_curve_points({p3_z, p3_y, p3_x, p2_z, p2_y, p2_x,
					p1_z, p1_y, p1_x, p0_z, p0_y, p0_x});
			if (out_valid && !out_stall) begin
				if (points_due.size() == 0) begin
					note_failure($sformatf("unexpected word %h %h %h last %b",
						point_x, point_y, point_z, last_point));
				end else begin
					want = points_due.pop_front();
					check_field("point_x", want.x, point_x);
					check_field("point_y", want.y, point_y);
					check_field("point_z", want.z, point_z);
					check_field("last_point", COORD_WIDTH'(want.last), COORD_WIDTH'(last_point));
				end
			end
			pending = points_due.size();
		end
	end

endmodule

### test/tb_cubic_bezier_forward_difference.sv
// testbench top: reset, resolution writes, segment and stall stimulus, final verdict
module tb_cubic_bezier_forward_difference;
	timeunit 1ns;
	timeprecision 1ps;

	import cbfd_pkg::*;

	localparam int LIMIT_CYCLES  = 2_000_000;
	localparam int SETTLE_CYCLES = 16;
	localparam int DRAIN_CYCLES  = 600;
	localparam int PHASES        = 11;
	localparam int PHASE_ITEMS   = 40;

	localparam logic [APB_AW-1:0] ADDR_RESOLUTION = {REG_RESOLUTION, 2'b00};
	localparam logic [APB_AW-1:0] ADDR_UNMAPPED   = {~REG_RESOLUTION, 2'b00};

	localparam logic [COORD_WIDTH-1:0] COORD_MAX  = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic [COORD_WIDTH-1:0] COORD_MIN  = {1'b1, {(COORD_WIDTH-1){1'b0}}};
	localparam logic [COORD_WIDTH-1:0] COORD_ONES = {COORD_WIDTH{1'b1}};
	localparam logic [COORD_WIDTH-1:0] COORD_ONE  = COORD_WIDTH'(1) << 16;

	typedef logic [11:0][COORD_WIDTH-1:0] segment_t;

	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [APB_AW-1:0]             paddr;
	logic [APB_DW-1:0]             pwdata;
	logic [APB_DW-1:0]             prdata;
	logic                          pready;
	logic                          in_valid;
	logic                          in_stall;
	logic signed [COORD_WIDTH-1:0] p0_x, p0_y, p0_z;
	logic signed [COORD_WIDTH-1:0] p1_x, p1_y, p1_z;
	logic signed [COORD_WIDTH-1:0] p2_x, p2_y, p2_z;
	logic signed [COORD_WIDTH-1:0] p3_x, p3_y, p3_z;
	logic                          out_valid;
	logic                          out_stall;
	logic signed [COORD_WIDTH-1:0] point_x, point_y, point_z;
	logic                          last_point;
	int                            failures;
	int                            pending;
	logic                          idle_enable;
	int                            cycle_count;

	cubic_bezier_forward_difference dut (.*);

	cubic_bezier_forward_difference_checker checker_i (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [COORD_WIDTH-1:0] random_coord();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: return COORD_MAX;
					1: return COORD_MIN;
					2: return COORD_ONES;
					default: return '0;
				endcase
			end
			1, 2, 3: return COORD_WIDTH'($urandom);
			// typical drawing coordinates within +-16 units
			default: return COORD_WIDTH'(int'($urandom_range(0, 2 ** 21)) - 2 ** 20);
		endcase
	endfunction

	function automatic segment_t same_on_axes(input logic [COORD_WIDTH-1:0] v0, v1, v2, v3);
		return {{3{v3}}, {3{v2}}, {3{v1}}, {3{v0}}};
	endfunction

	task automatic send_segment(input segment_t s);
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		p0_x <= s[0];
		p0_y <= s[1];
		p0_z <= s[2];
		p1_x <= s[3];
		p1_y <= s[4];
		p1_z <= s[5];
		p2_x <= s[6];
		p2_y <= s[7];
		p2_z <= s[8];
		p3_x <= s[9];
		p3_y <= s[10];
		p3_z <= s[11];
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic cfg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// pending is read on the falling edge, after the checker has updated it on the rising edge
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (idle_enable && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("cubic_bezier_forward_difference: mismatch");
		$finish;
	end

	initial begin
		segment_t     directed_segs[8];
		int           extreme_res[4];
		logic [RES_W-1:0] res;
		arst_n <= 1'b0;
		idle_enable <= 1'b1;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		{p0_x, p0_y, p0_z, p1_x, p1_y, p1_z} <= '0;
		{p2_x, p2_y, p2_z, p3_x, p3_y, p3_z} <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_segs[0] = same_on_axes('0, '0, '0, '0);
		directed_segs[1] = same_on_axes(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		directed_segs[2] = same_on_axes(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
		// largest curvature terms, the accumulators wrap
		directed_segs[3] = same_on_axes(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
		directed_segs[4] = same_on_axes(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
		directed_segs[5] = same_on_axes(COORD_ONES, COORD_ONES, COORD_ONES, COORD_ONES);
		// straight line with evenly spaced handles, no cubic term
		directed_segs[6] = same_on_axes('0, COORD_ONE, 2 * COORD_ONE, 3 * COORD_ONE);
		directed_segs[7] = {random_coord(), random_coord(), random_coord(),
			COORD_WIDTH'(32'h0002_0000), COORD_WIDTH'(32'h0004_4000), COORD_WIDTH'(32'hFFFD_8000),
			COORD_WIDTH'(32'hFFFF_0001), COORD_WIDTH'(32'h0001_8000), COORD_WIDTH'(32'h0003_0000),
			random_coord(), random_coord(), random_coord()};

		// default resolution after reset
		foreach (directed_segs[k])
			send_segment(directed_segs[k]);

		// a write to an address past the register list must not touch resolution
		wait_drained();
		cfg_write(ADDR_UNMAPPED, 32'd5);
		send_segment(directed_segs[3]);
		send_segment(directed_segs[6]);

		extreme_res = '{1, MAX_RESOLUTION, 0, 127};
		foreach (extreme_res[k]) begin
			wait_drained();
			cfg_write(ADDR_RESOLUTION, APB_DW'(extreme_res[k]));
			send_segment(directed_segs[3]);
			send_segment(directed_segs[7]);
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			wait_drained();
			case (phase)
				0: res = RES_W'(MAX_RESOLUTION + 1);
				1: res = RES_W'(MAX_RESOLUTION);
				2: res = 1;
				3: res = 0;
				default: begin
					if ($urandom_range(0, 5) == 0)
						res = RES_W'($urandom_range(MAX_RESOLUTION + 1, 127));
					else
						res = RES_W'($urandom_range(1, MAX_RESOLUTION));
				end
			endcase
			// upper data bits carry noise, only the low bits hold the register
			cfg_write(ADDR_RESOLUTION, ($urandom & ~APB_DW'(2 ** RES_W - 1)) | APB_DW'(res));
			idle_enable <= (phase < PHASES - 2) && (phase % 3 != 1);
			repeat (PHASE_ITEMS)
				send_segment({random_coord(), random_coord(), random_coord(),
					random_coord(), random_coord(), random_coord(),
					random_coord(), random_coord(), random_coord(),
					random_coord(), random_coord(), random_coord()});
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("cubic_bezier_forward_difference: match");
		else
			$display("cubic_bezier_forward_difference: mismatch");
		$finish;
	end

endmodule
